>>> hw/rtl/lbh_pkg.sv
// ----------------------------------------------------------------------------
// lbh_pkg
// Types, constants and mixing functions shared by the lookup2 hash unit.
// ----------------------------------------------------------------------------
`default_nettype none

package lbh_pkg;

    localparam logic [31:0] GOLDEN_RATIO = 32'h9E3779B9;
    localparam logic [31:0] BLOCK_BYTES  = 32'h0000000C;
    localparam logic [3:0]  MAX_TAIL     = 4'hB;

    localparam logic [1:0] ROUND_FIRST  = 2'd0;
    localparam logic [1:0] ROUND_SECOND = 2'd1;
    localparam logic [1:0] ROUND_LAST   = 2'd2;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
    } lbh_words_t;

    typedef struct packed {
        logic [31:0] add_a;
        logic [31:0] add_b;
        logic [31:0] add_c;
        logic        first;
        logic        last;
    } lbh_job_t;

    function automatic logic [31:0] low_bytes(input logic [31:0] w, input logic [3:0] n);
        logic [31:0] r;
        case (n)
            4'd0:    r = 32'h0;
            4'd1:    r = {24'h0, w[7:0]};
            4'd2:    r = {16'h0, w[15:0]};
            4'd3:    r = {8'h0, w[23:0]};
            default: r = w;
        endcase
        return r;
    endfunction

    // One third of the lookup2 mix: one pass over a, b and c.
    function automatic lbh_words_t mix_round(input lbh_words_t s, input logic [1:0] round);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        lbh_words_t  r;
        a = s.a;
        b = s.b;
        c = s.c;
        case (round)
            ROUND_FIRST:
            begin
                a = (a - b - c) ^ (c >> 13);
                b = (b - c - a) ^ (a << 8);
                c = (c - a - b) ^ (b >> 13);
            end
            ROUND_SECOND:
            begin
                a = (a - b - c) ^ (c >> 12);
                b = (b - c - a) ^ (a << 16);
                c = (c - a - b) ^ (b >> 5);
            end
            default:
            begin
                a = (a - b - c) ^ (c >> 3);
                b = (b - c - a) ^ (a << 10);
                c = (c - a - b) ^ (b >> 15);
            end
        endcase
        r.a = a;
        r.b = b;
        r.c = c;
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/lookup2_block_hash_unit.sv
// ----------------------------------------------------------------------------
// lookup2_block_hash_unit
// Lookup2 32-bit message hash, one 12-byte block per request.
//
//   Channel   Direction  Handshake                     Payload
//   in        input      in_valid / in_ready           word_low, word_mid, word_high,
//                                                      tail_count, last_item
//   out       output     out_valid / out_ready         hash_value
//   cfg       input      cfg_write_enable              cfg_write_data (seed)
//
// In the back end each request is first added into the running state and then
// passes through three mix rounds in the shared round unit.
// The front end accepts a request every cycle while the queue has room.
// Reset clears the queue, the length counter and the output valid flag.
// A pending hash that is not taken holds the back end before its last round.
// ----------------------------------------------------------------------------
`default_nettype none

module lookup2_block_hash_unit
    import lbh_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write_enable,
    input  wire logic [31:0] cfg_write_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] word_low,
    input  wire logic [31:0] word_mid,
    input  wire logic [31:0] word_high,
    input  wire logic [3:0]  tail_count,
    input  wire logic        last_item,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      hash_value
);

    logic [31:0] seed_reg;
    logic        push_valid;
    logic        push_ready;
    lbh_job_t    push_job;
    logic        pop_valid;
    logic        pop_ready;
    lbh_job_t    pop_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= 32'h0;
        end
        else if (cfg_write_enable)
        begin
            seed_reg <= cfg_write_data;
        end
    end

    lbh_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .word_low   (word_low),
        .word_mid   (word_mid),
        .word_high  (word_high),
        .tail_count (tail_count),
        .last_item  (last_item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    lbh_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    lbh_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .seed       (seed_reg),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .hash_value (hash_value)
    );

endmodule

`default_nettype wire

>>> hw/rtl/lbh_front.sv
// ----------------------------------------------------------------------------
// lbh_front
// Accepts requests, tracks message length and builds the word addends.
// ----------------------------------------------------------------------------
`default_nettype none

module lbh_front
    import lbh_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] word_low,
    input  wire logic [31:0] word_mid,
    input  wire logic [31:0] word_high,
    input  wire logic [3:0]  tail_count,
    input  wire logic        last_item,
    output logic             push_valid,
    input  wire logic        push_ready,
    output lbh_job_t         push_job
);

    logic [31:0] byte_total_reg;
    logic [31:0] byte_total_next;
    logic        fresh_reg;
    logic        fresh_next;
    logic [3:0]  tail;
    logic [3:0]  n_mid;
    logic [3:0]  n_high;
    logic [31:0] base_total;
    logic [31:0] total;
    logic [31:0] high_bytes;
    logic        accept;

    assign in_ready   = push_ready;
    assign push_valid = in_valid;
    assign accept     = in_valid && push_ready;

    always_comb
    begin
        tail       = (tail_count > MAX_TAIL) ? MAX_TAIL : tail_count;
        n_mid      = (tail > 4'd4) ? tail - 4'd4 : 4'd0;
        n_high     = (tail > 4'd8) ? tail - 4'd8 : 4'd0;
        base_total = fresh_reg ? 32'h0 : byte_total_reg;
        total      = base_total + {28'h0, tail};
        high_bytes = low_bytes(word_high, n_high);

        push_job.first = fresh_reg;
        push_job.last  = last_item;
        if (last_item)
        begin
            push_job.add_a = low_bytes(word_low, tail);
            push_job.add_b = low_bytes(word_mid, n_mid);
            push_job.add_c = total + {high_bytes[23:0], 8'h0};
        end
        else
        begin
            push_job.add_a = word_low;
            push_job.add_b = word_mid;
            push_job.add_c = word_high;
        end

        byte_total_next = byte_total_reg;
        fresh_next      = fresh_reg;
        if (accept)
        begin
            byte_total_next = last_item ? 32'h0 : base_total + BLOCK_BYTES;
            fresh_next      = last_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_total_reg <= 32'h0;
            fresh_reg      <= 1'b1;
        end
        else
        begin
            byte_total_reg <= byte_total_next;
            fresh_reg      <= fresh_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/lbh_queue.sv
// ----------------------------------------------------------------------------
// lbh_queue
// Small first-in first-out buffer of jobs between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module lbh_queue
    import lbh_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push_valid,
    output logic          push_ready,
    input  wire lbh_job_t push_job,
    output logic          pop_valid,
    input  wire logic     pop_ready,
    output lbh_job_t      pop_job
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    lbh_job_t      mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          do_push;
    logic          do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/lbh_back.sv
// ----------------------------------------------------------------------------
// lbh_back
// Adds each job into the running words, mixes in three rounds, emits hashes.
// ----------------------------------------------------------------------------
`default_nettype none

module lbh_back
    import lbh_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [31:0] seed,
    input  wire logic        pop_valid,
    output logic             pop_ready,
    input  wire lbh_job_t    pop_job,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      hash_value
);

    lbh_words_t  state_reg;
    lbh_words_t  state_next;
    lbh_words_t  mixed;
    logic        busy_reg;
    logic        busy_next;
    logic [1:0]  round_reg;
    logic [1:0]  round_next;
    logic        last_reg;
    logic        last_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [31:0] hash_reg;
    logic [31:0] hash_next;
    logic        can_step;

    assign pop_ready  = !busy_reg;
    assign out_valid  = out_valid_reg;
    assign hash_value = hash_reg;
    assign mixed      = mix_round(state_reg, round_reg);
    assign can_step   = !(round_reg == ROUND_LAST && last_reg) || !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        busy_next      = busy_reg;
        round_next     = round_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        hash_next      = hash_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (!busy_reg)
        begin
            if (pop_valid)
            begin
                state_next.a = (pop_job.first ? GOLDEN_RATIO : state_reg.a) + pop_job.add_a;
                state_next.b = (pop_job.first ? GOLDEN_RATIO : state_reg.b) + pop_job.add_b;
                state_next.c = (pop_job.first ? seed : state_reg.c) + pop_job.add_c;
                busy_next    = 1'b1;
                round_next   = ROUND_FIRST;
                last_next    = pop_job.last;
            end
        end
        else if (can_step)
        begin
            state_next = mixed;
            round_next = round_reg + 2'd1;
            if (round_reg == ROUND_LAST)
            begin
                busy_next = 1'b0;
                if (last_reg)
                begin
                    out_valid_next = 1'b1;
                    hash_next      = mixed.c;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            round_reg     <= ROUND_FIRST;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            round_reg     <= round_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        state_reg <= state_next;
        hash_reg  <= hash_next;
    end

endmodule

`default_nettype wire
